/* src/assert_macros.svh */
// Assertion helpers shared by the RTL files.
// All checks sample on clk_i and are disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

/* src/tlqi_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tlqi_pkg;

  // Field and datapath widths
  localparam int unsigned COORD_W    = 9;
  localparam int unsigned LOD_W      = 3;
  localparam int unsigned NLOD_W     = 4;
  localparam int unsigned BASE_W     = 18;
  localparam int unsigned PROD_W     = 28;
  localparam int unsigned IDX_W      = 20;
  localparam int unsigned GW_W       = 11;
  localparam int unsigned VC_W       = 21;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 21;
  localparam int unsigned N_CORNER   = 4;

  // Corner slots: (x,z), (x+s,z), (x,z+s), (x+s,z+s)
  localparam int unsigned C11 = 0;
  localparam int unsigned C21 = 1;
  localparam int unsigned C12 = 2;
  localparam int unsigned C22 = 3;

  // Grid width ceiling
  localparam logic [GW_W-1:0] GRID_MAX = 11'd1024;

  // Register reset values
  localparam logic [LOD_W-1:0] RST_MAX_LOD      = 3'd5;
  localparam logic [GW_W-1:0]  RST_GRID_WIDTH   = 11'd128;
  localparam logic [VC_W-1:0]  RST_VERTEX_COUNT = 21'd16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_LOD      = 2'd0,
    CFG_GRID_WIDTH   = 2'd1,
    CFG_VERTEX_COUNT = 2'd2
  } cfg_idx_e;

  // Per-request patch context shared by the four corners
  typedef struct packed {
    logic [COORD_W-1:0] ext_r;
    logic [COORD_W-1:0] ext_c;
    logic [LOD_W-1:0]   lod_self;
    logic [COORD_W-1:0] edge_len;
    logic [NLOD_W-1:0]  lod_top;
    logic [NLOD_W-1:0]  lod_bottom;
    logic [NLOD_W-1:0]  lod_west;
    logic [NLOD_W-1:0]  lod_east;
  } tlqi_ctx_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] z;
  } tlqi_pt_t;

  // First stage contents handed to the index stages
  typedef struct packed {
    logic                       valid;
    tlqi_pt_t [N_CORNER-1:0]    pt;
    logic [BASE_W-1:0]          row_base;
    logic [BASE_W-1:0]          col_base;
  } tlqi_s1_t;

endpackage

`default_nettype wire

/* src/tlqi_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface tlqi_req_if;
  logic              valid;
  logic              ready;
  logic [8:0]        tile_row;
  logic [8:0]        tile_col;
  logic [7:0]        quad_x;
  logic [7:0]        quad_z;
  logic [2:0]        lod_self;
  logic signed [3:0] lod_top;
  logic signed [3:0] lod_bottom;
  logic signed [3:0] lod_west;
  logic signed [3:0] lod_east;
  logic [8:0]        extent_rows;
  logic [8:0]        extent_cols;

  modport source (
    output valid, tile_row, tile_col, quad_x, quad_z, lod_self,
           lod_top, lod_bottom, lod_west, lod_east, extent_rows, extent_cols,
    input  ready
  );

  modport sink (
    input  valid, tile_row, tile_col, quad_x, quad_z, lod_self,
           lod_top, lod_bottom, lod_west, lod_east, extent_rows, extent_cols,
    output ready
  );
endinterface

`default_nettype wire

/* src/tlqi_res_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface tlqi_res_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [19:0] first_index;
  logic [19:0] second_index;
  logic [19:0] third_index;
  logic [19:0] fourth_index;
  logic [19:0] fifth_index;
  logic [19:0] sixth_index;

  modport source (
    output valid, valid_res, first_index, second_index, third_index,
           fourth_index, fifth_index, sixth_index,
    input  ready
  );

  modport sink (
    input  valid, valid_res, first_index, second_index, third_index,
           fourth_index, fifth_index, sixth_index,
    output ready
  );
endinterface

`default_nettype wire

/* src/tlqi_corner.sv */
`timescale 1ns / 1ps
`default_nettype none

module tlqi_corner (
  input  tlqi_pkg::tlqi_ctx_t          ctx_i,
  input  logic [tlqi_pkg::COORD_W-1:0] x_i,
  input  logic [tlqi_pkg::COORD_W-1:0] z_i,
  output tlqi_pkg::tlqi_pt_t           pt_o
);
  import tlqi_pkg::*;

  // Snap down to a coarser neighbour's grid; negative level means no neighbour
  function automatic logic [COORD_W-1:0] snap(
    input logic [COORD_W-1:0] v,
    input logic [NLOD_W-1:0]  nl,
    input logic [LOD_W-1:0]   self_lod
  );
    logic [COORD_W-1:0] keep;
    keep = {COORD_W{1'b1}} << nl[LOD_W-1:0];
    if (!nl[NLOD_W-1] && (nl[LOD_W-1:0] > self_lod)) begin
      return v & keep;
    end
    return v;
  endfunction

  logic [COORD_W-1:0] x_clip, z_clip;
  logic [COORD_W-1:0] x_snap, z_snap;

  // Clip to extents, snap along borders, then pull back to the patch edge
  always_comb begin
    z_clip = (z_i > ctx_i.ext_r) ? ctx_i.ext_r : z_i;
    x_clip = (x_i > ctx_i.ext_c) ? ctx_i.ext_c : x_i;

    if (z_clip == '0) begin
      x_snap = snap(x_clip, ctx_i.lod_top, ctx_i.lod_self);
    end else if (z_clip == ctx_i.edge_len) begin
      x_snap = snap(x_clip, ctx_i.lod_bottom, ctx_i.lod_self);
    end else begin
      x_snap = x_clip;
    end

    if (x_snap == '0) begin
      z_snap = snap(z_clip, ctx_i.lod_west, ctx_i.lod_self);
    end else if (x_snap == ctx_i.edge_len) begin
      z_snap = snap(z_clip, ctx_i.lod_east, ctx_i.lod_self);
    end else begin
      z_snap = z_clip;
    end

    pt_o.z = (z_snap > ctx_i.edge_len) ? ctx_i.edge_len : z_snap;
    pt_o.x = (x_snap > ctx_i.edge_len) ? ctx_i.edge_len : x_snap;
  end

endmodule

`default_nettype wire

/* src/tlqi_coord_stage.sv */
`timescale 1ns / 1ps
`default_nettype none

module tlqi_coord_stage (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  tlqi_req_if.sink                     req,
  input  logic [tlqi_pkg::LOD_W-1:0]   max_lod_i,
  input  logic                         adv_i,
  output tlqi_pkg::tlqi_s1_t           s1_o
);
  import tlqi_pkg::*;

  tlqi_ctx_t                      ctx;
  logic [COORD_W-1:0]             step;
  logic [COORD_W-1:0]             x_lo, x_hi, z_lo, z_hi;
  logic [N_CORNER-1:0][COORD_W-1:0] cx, cz;
  tlqi_pt_t [N_CORNER-1:0]        pt;
  logic [LOD_W:0]                 base_sh;
  logic [BASE_W-1:0]              row_base, col_base;
  logic                           valid_q, valid_d;
  tlqi_pt_t [N_CORNER-1:0]        pt_q;
  logic [BASE_W-1:0]              row_base_q, col_base_q;
  logic                           advance;

  // Take a new request whenever this stage is empty or moves on
  assign advance   = !valid_q || adv_i;
  assign req.ready = advance;

  // Patch context and the four corner positions
  always_comb begin
    step           = COORD_W'(1) << req.lod_self;
    ctx.ext_r      = req.extent_rows;
    ctx.ext_c      = req.extent_cols;
    ctx.lod_self   = req.lod_self;
    ctx.edge_len   = COORD_W'(2) << max_lod_i;
    ctx.lod_top    = req.lod_top;
    ctx.lod_bottom = req.lod_bottom;
    ctx.lod_west   = req.lod_west;
    ctx.lod_east   = req.lod_east;

    x_lo = {1'b0, req.quad_x};
    z_lo = {1'b0, req.quad_z};
    x_hi = x_lo + step;
    z_hi = z_lo + step;

    cx[C11] = x_lo; cz[C11] = z_lo;
    cx[C21] = x_hi; cz[C21] = z_lo;
    cx[C12] = x_lo; cz[C12] = z_hi;
    cx[C22] = x_hi; cz[C22] = z_hi;

    // Patch origin in the grid is the tile position times the edge length
    base_sh  = {1'b0, max_lod_i} + (LOD_W+1)'(1);
    row_base = BASE_W'(req.tile_row) << base_sh;
    col_base = BASE_W'(req.tile_col) << base_sh;
  end

  for (genvar k = 0; k < N_CORNER; k++) begin : g_corner
    tlqi_corner u_corner (
      .ctx_i (ctx),
      .x_i   (cx[k]),
      .z_i   (cz[k]),
      .pt_o  (pt[k])
    );
  end

  assign valid_d = advance ? req.valid : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload loads on advance, holds while stalled
  always_ff @(posedge clk_i) begin
    if (advance) begin
      pt_q       <= pt;
      row_base_q <= row_base;
      col_base_q <= col_base;
    end
  end

  always_comb begin
    s1_o.valid    = valid_q;
    s1_o.pt       = pt_q;
    s1_o.row_base = row_base_q;
    s1_o.col_base = col_base_q;
  end

endmodule

`default_nettype wire

/* src/tlqi_index_stage.sv */
`timescale 1ns / 1ps
`default_nettype none

module tlqi_index_stage (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tlqi_pkg::tlqi_s1_t          s1_i,
  input  logic [tlqi_pkg::GW_W-1:0]   grid_width_i,
  input  logic [tlqi_pkg::VC_W-1:0]   vertex_count_i,
  output logic                        adv_o,
  tlqi_res_if.source                  res
);
  import tlqi_pkg::*;

  logic [GW_W-1:0]                     gw_sat;
  logic [N_CORNER-1:0][BASE_W-1:0]     zr, xc;
  logic [N_CORNER-1:0][PROD_W-1:0]     prod;
  logic [N_CORNER-1:0][PROD_W-1:0]     prod_q;
  logic [N_CORNER-1:0][BASE_W-1:0]     xc_q;
  logic                                mul_valid_q;
  logic [N_CORNER-1:0][PROD_W-1:0]     idx;
  logic [N_CORNER-1:0]                 in_range;
  logic                                all_ok;
  logic [N_CORNER-1:0][IDX_W-1:0]      idx_d, idx_q;
  logic                                out_valid_q, ok_q;
  logic                                adv_mul, adv_out;

  // Stall chain from the result side back to the first stage
  assign adv_out = !out_valid_q || res.ready;
  assign adv_mul = !mul_valid_q || adv_out;
  assign adv_o   = adv_mul;

  assign gw_sat = (grid_width_i > GRID_MAX) ? GRID_MAX : grid_width_i;

  // Row offset times grid width, one multiplier per corner
  always_comb begin
    for (int k = 0; k < N_CORNER; k++) begin
      zr[k]   = BASE_W'(s1_i.pt[k].z) + s1_i.row_base;
      xc[k]   = BASE_W'(s1_i.pt[k].x) + s1_i.col_base;
      prod[k] = PROD_W'(zr[k] * gw_sat);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
    end else if (adv_mul) begin
      mul_valid_q <= s1_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_mul) begin
      prod_q <= prod;
      xc_q   <= xc;
    end
  end

  // Final add, range check against the buffer size, zero the invalid case
  always_comb begin
    for (int k = 0; k < N_CORNER; k++) begin
      idx[k]      = prod_q[k] + PROD_W'(xc_q[k]);
      in_range[k] = idx[k] < PROD_W'(vertex_count_i);
    end
    all_ok = &in_range;
    for (int k = 0; k < N_CORNER; k++) begin
      idx_d[k] = all_ok ? idx[k][IDX_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_out) begin
      out_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_out) begin
      ok_q  <= all_ok;
      idx_q <= idx_d;
    end
  end

  assign res.valid        = out_valid_q;
  assign res.valid_res    = ok_q;
  assign res.first_index  = idx_q[C12];
  assign res.second_index = idx_q[C11];
  assign res.third_index  = idx_q[C22];
  assign res.fourth_index = idx_q[C22];
  assign res.fifth_index  = idx_q[C11];
  assign res.sixth_index  = idx_q[C21];

endmodule

`default_nettype wire

/* src/terrain_lod_quad_indexer_top.sv */
// Throughput: one quad per cycle unless res.ready stalls the pipeline; the three
//   register stages are corner placement, row-times-width multiply, and final
//   add with range check, passed through in that order.
// Reset: rst_ni is asynchronous and active low; it empties the pipeline and
//   returns max_lod, grid_width and vertex_count to 5, 128 and 16384.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module terrain_lod_quad_indexer_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tlqi_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tlqi_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  tlqi_req_if.sink                         req,
  tlqi_res_if.source                       res
);
  import tlqi_pkg::*;

  logic [LOD_W-1:0] max_lod_q;
  logic [GW_W-1:0]  grid_width_q;
  logic [VC_W-1:0]  vertex_count_q;
  tlqi_s1_t         s1;
  logic             adv;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_lod_q      <= RST_MAX_LOD;
      grid_width_q   <= RST_GRID_WIDTH;
      vertex_count_q <= RST_VERTEX_COUNT;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MAX_LOD:      max_lod_q      <= cfg_data_i[LOD_W-1:0];
        CFG_GRID_WIDTH:   grid_width_q   <= cfg_data_i[GW_W-1:0];
        CFG_VERTEX_COUNT: vertex_count_q <= cfg_data_i[VC_W-1:0];
        default: ;
      endcase
    end
  end

  tlqi_coord_stage u_coord (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req       (req),
    .max_lod_i (max_lod_q),
    .adv_i     (adv),
    .s1_o      (s1)
  );

  tlqi_index_stage u_index (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s1_i           (s1),
    .grid_width_i   (grid_width_q),
    .vertex_count_i (vertex_count_q),
    .adv_o          (adv),
    .res            (res)
  );

  // An invalid quad carries all-zero indices
  `ASSERT_IMPLIES(a_invalid_zero, res.valid && !res.valid_res,
    (res.first_index == '0) && (res.second_index == '0) && (res.third_index == '0)
    && (res.sixth_index == '0), "invalid quad with non-zero index")

  // Shared corners of the two triangles agree
  `ASSERT_IMPLIES(a_shared_corners, res.valid && res.valid_res,
    (res.fourth_index == res.third_index) && (res.fifth_index == res.second_index),
    "shared triangle corners differ")

  // With no result waiting nothing can stall the input side
  `ASSERT_IMPLIES(a_ready_when_drained, !res.valid, req.ready,
    "request refused while output stage empty")

  // First stage holds a request only after one was taken
  `ASSERT_IMPLIES(a_s1_source, $rose(s1.valid), $past(req.valid && req.ready),
    "first stage filled without an accepted request")

endmodule

`default_nettype wire

/* sim/tlqi_checker.sv */
`timescale 1ns / 1ps

// Watch the request, result and register channels, predict the six indices
// of every accepted quad and compare them with what comes out, in order.
module tlqi_checker
  import tlqi_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  tlqi_req_if                   req,
  tlqi_res_if                   res,
  output int                    fail_count_o,
  output int                    pending_quads_o,
  output int                    results_seen_o,
  output int                    out_of_range_o
);

  localparam int unsigned LOD_LIMIT = 7;

  typedef struct packed {
    logic [8:0] row;
    logic [8:0] col;
    logic [7:0] qx;
    logic [7:0] qz;
    logic [2:0] lod;
    logic [3:0] top;
    logic [3:0] bottom;
    logic [3:0] left;
    logic [3:0] right;
    logic [8:0] ext_r;
    logic [8:0] ext_c;
  } quad_req_t;

  typedef struct packed {
    logic             valid_res;
    logic [IDX_W-1:0] first_idx;
    logic [IDX_W-1:0] second_idx;
    logic [IDX_W-1:0] third_idx;
    logic [IDX_W-1:0] fourth_idx;
    logic [IDX_W-1:0] fifth_idx;
    logic [IDX_W-1:0] sixth_idx;
  } quad_tris_t;

  logic [LOD_W-1:0] max_lod_q      = RST_MAX_LOD;
  logic [GW_W-1:0]  grid_width_q   = RST_GRID_WIDTH;
  logic [VC_W-1:0]  vertex_count_q = RST_VERTEX_COUNT;

  quad_tris_t expected_tris[$];
  int         errors       = 0;
  int         results_seen = 0;
  int         out_of_range = 0;

  function automatic int unsigned clamp_lod(int unsigned v);
    return (v > LOD_LIMIT) ? LOD_LIMIT : v;
  endfunction

  // A set sign bit means the neighbour is absent
  function automatic int neighbour_level(logic [3:0] raw);
    if (raw[3]) return -1;
    return int'(clamp_lod(raw));
  endfunction

  // Drop a coordinate onto the grid of a coarser neighbour
  function automatic int unsigned snap_down(int unsigned v, int lvl, int unsigned self_lod);
    int unsigned grain;
    if (lvl < 0) return v;
    if (unsigned'(lvl) <= self_lod) return v;
    grain = 1 << lvl;
    return v - (v % grain);
  endfunction

  function automatic longint unsigned corner_index(int unsigned x, int unsigned z,
                                                    quad_req_t q, int unsigned self_lod,
                                                    int unsigned span);
    longint unsigned gw;
    gw = (grid_width_q > GRID_MAX) ? GRID_MAX : grid_width_q;

    // Clamp to the clipped extents
    if (z > q.ext_r) z = q.ext_r;
    if (x > q.ext_c) x = q.ext_c;

    // Stitch top/bottom edges along x, then left/right edges along z
    if (z == 0)         x = snap_down(x, neighbour_level(q.top), self_lod);
    else if (z == span) x = snap_down(x, neighbour_level(q.bottom), self_lod);
    if (x == 0)         z = snap_down(z, neighbour_level(q.left), self_lod);
    else if (x == span) z = snap_down(z, neighbour_level(q.right), self_lod);

    // Pull back anything past the patch edge
    if (z > span) z = span;
    if (x > span) x = span;

    return (longint'(z) + longint'(span) * q.row) * gw + x + longint'(span) * q.col;
  endfunction

  function automatic quad_tris_t predict_tris(quad_req_t q);
    int unsigned     self_lod;
    int unsigned     step;
    int unsigned     span;
    longint unsigned i11;
    longint unsigned i21;
    longint unsigned i12;
    longint unsigned i22;
    quad_tris_t      t;
    self_lod = clamp_lod(q.lod);
    step     = 1 << self_lod;
    span     = 2 << clamp_lod(max_lod_q);
    i11 = corner_index(q.qx,        q.qz,        q, self_lod, span);
    i21 = corner_index(q.qx + step, q.qz,        q, self_lod, span);
    i12 = corner_index(q.qx,        q.qz + step, q, self_lod, span);
    i22 = corner_index(q.qx + step, q.qz + step, q, self_lod, span);
    t = '0;
    if (i11 < vertex_count_q && i21 < vertex_count_q &&
        i12 < vertex_count_q && i22 < vertex_count_q) begin
      t.valid_res  = 1'b1;
      t.first_idx  = i12[IDX_W-1:0];
      t.second_idx = i11[IDX_W-1:0];
      t.third_idx  = i22[IDX_W-1:0];
      t.fourth_idx = i22[IDX_W-1:0];
      t.fifth_idx  = i11[IDX_W-1:0];
      t.sixth_idx  = i21[IDX_W-1:0];
    end
    return t;
  endfunction

  task automatic check_field(string name, logic [IDX_W-1:0] want, logic [IDX_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    quad_req_t  q;
    quad_tris_t want;
    if (!rst_ni) begin
      max_lod_q      = RST_MAX_LOD;
      grid_width_q   = RST_GRID_WIDTH;
      vertex_count_q = RST_VERTEX_COUNT;
      expected_tris.delete();
      pending_quads_o <= 0;
    end else begin
      // Retire the oldest expectation against each result taken
      if (res.valid && res.ready) begin
        results_seen++;
        if (!res.valid_res) out_of_range++;
        if (expected_tris.size() == 0) begin
          $error("result arrived with no request outstanding");
          errors++;
        end else begin
          want = expected_tris.pop_front();
          check_field("valid_res",    want.valid_res,  res.valid_res);
          check_field("first_index",  want.first_idx,  res.first_index);
          check_field("second_index", want.second_idx, res.second_index);
          check_field("third_index",  want.third_idx,  res.third_index);
          check_field("fourth_index", want.fourth_idx, res.fourth_index);
          check_field("fifth_index",  want.fifth_idx,  res.fifth_index);
          check_field("sixth_index",  want.sixth_idx,  res.sixth_index);
        end
      end

      // Predict each accepted request with the settings in force
      if (req.valid && req.ready) begin
        q.row    = req.tile_row;
        q.col    = req.tile_col;
        q.qx     = req.quad_x;
        q.qz     = req.quad_z;
        q.lod    = req.lod_self;
        q.top    = req.lod_top;
        q.bottom = req.lod_bottom;
        q.left   = req.lod_west;
        q.right  = req.lod_east;
        q.ext_r  = req.extent_rows;
        q.ext_c  = req.extent_cols;
        expected_tris = {expected_tris, predict_tris(q)};
      end

      // Track register writes; the spare index is dropped
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MAX_LOD:      max_lod_q      = cfg_data_i[LOD_W-1:0];
          CFG_GRID_WIDTH:   grid_width_q   = cfg_data_i[GW_W-1:0];
          CFG_VERTEX_COUNT: vertex_count_q = cfg_data_i[VC_W-1:0];
          default: ;
        endcase
      end
      pending_quads_o <= expected_tris.size();
    end
    fail_count_o   <= errors;
    results_seen_o <= results_seen;
    out_of_range_o <= out_of_range;
  end

endmodule

/* sim/tb_terrain_lod_quad_indexer_top.sv */
`timescale 1ns / 1ps

module tb_terrain_lod_quad_indexer_top;
  import tlqi_pkg::*;

  localparam int unsigned CLK_PERIOD   = 8;
  localparam int unsigned QUAD_TARGET  = 1900;
  localparam int unsigned PHASE_QUADS  = 240;
  localparam int unsigned N_PHASES     = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int mismatches;
  int pending_quads;
  int results_seen;
  int out_of_range;

  int          send_idle_pct = 28;
  int          recv_idle_pct = 83;
  int          sent_quads    = 0;
  int          settings_used = 1;
  int unsigned set_max_lod   = RST_MAX_LOD;
  int unsigned set_grid_w    = RST_GRID_WIDTH;
  int unsigned set_vcount    = RST_VERTEX_COUNT;

  tlqi_req_if req_ch ();
  tlqi_res_if res_ch ();

  terrain_lod_quad_indexer_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req        (req_ch),
    .res        (res_ch)
  );

  tlqi_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .req             (req_ch),
    .res             (res_ch),
    .fail_count_o    (mismatches),
    .pending_quads_o (pending_quads),
    .results_seen_o  (results_seen),
    .out_of_range_o  (out_of_range)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Stall the result side at the current rate
  always @(posedge clk_i) begin
    res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Hard stop in case the pipeline hangs
  initial begin
    #(4_000_000);
    $display("Mismatches found");
    $finish;
  end

  // Swap which side idles as the run goes on, then stop idling
  function automatic void pick_idle_rates();
    if (sent_quads < QUAD_TARGET / 3) begin
      send_idle_pct = 28;
      recv_idle_pct = 83;
    end else if (sent_quads < 2 * QUAD_TARGET / 3) begin
      send_idle_pct = 83;
      recv_idle_pct = 28;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endfunction

  // Hold one request until the block takes it
  task automatic send_quad(int row, int col, int qx, int qz, int lod,
                           int top, int bottom, int left, int right,
                           int ext_r, int ext_c);
    pick_idle_rates();
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid       <= 1'b1;
    req_ch.tile_row    <= 9'(row);
    req_ch.tile_col    <= 9'(col);
    req_ch.quad_x      <= 8'(qx);
    req_ch.quad_z      <= 8'(qz);
    req_ch.lod_self    <= 3'(lod);
    req_ch.lod_top     <= 4'(top);
    req_ch.lod_bottom  <= 4'(bottom);
    req_ch.lod_west    <= 4'(left);
    req_ch.lod_east    <= 4'(right);
    req_ch.extent_rows <= 9'(ext_r);
    req_ch.extent_cols <= 9'(ext_c);
    do @(posedge clk_i); while (!req_ch.ready);
    sent_quads++;
  endtask

  // Drop valid and hold off until every outstanding result is back
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_quads != 0);
  endtask

  // Write all registers once the pipeline is empty, then poke the spare index
  task automatic apply_settings(int unsigned ml, int unsigned gw, int unsigned vc);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_MAX_LOD;
    cfg_data_i <= CFG_DATA_W'(ml);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_GRID_WIDTH;
    cfg_data_i <= CFG_DATA_W'(gw);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_VERTEX_COUNT;
    cfg_data_i <= CFG_DATA_W'(vc);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_SPARE;
    cfg_data_i <= CFG_DATA_W'($urandom);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    set_max_lod = ml & 32'h7;
    set_grid_w  = gw & 32'h7FF;
    set_vcount  = vc & 32'h1FFFFF;
    settings_used++;
  endtask

  // Mostly present neighbours, now and then an absent one
  function automatic int rand_neighbour();
    if ($urandom_range(5) == 0) return $urandom_range(15, 8);
    return $urandom_range(7);
  endfunction

  // Mostly aligned quads inside the patch with rows and columns that fit;
  // the rest is raw noise over every field
  task automatic send_random_quad();
    int unsigned span;
    int unsigned gw_eff;
    int unsigned lod;
    int unsigned step;
    int unsigned rmax;
    int unsigned cmax;
    int unsigned ext_r;
    int unsigned ext_c;
    span   = 2 << set_max_lod;
    gw_eff = (set_grid_w > GRID_MAX) ? GRID_MAX : set_grid_w;
    if ($urandom_range(99) < 25) begin
      send_quad($urandom_range(511), $urandom_range(511), $urandom_range(255),
                $urandom_range(255), $urandom_range(7), $urandom_range(15),
                $urandom_range(15), $urandom_range(15), $urandom_range(15),
                $urandom_range(511), $urandom_range(511));
    end else begin
      lod  = $urandom_range((set_max_lod + 1 > 7) ? 7 : set_max_lod + 1);
      step = 1 << lod;
      rmax = (gw_eff == 0) ? 511 : set_vcount / (span * gw_eff);
      rmax = (rmax > 0) ? rmax - 1 : 0;
      rmax = (rmax > 511) ? 511 : rmax;
      cmax = gw_eff / span;
      cmax = (cmax > 0) ? cmax - 1 : 0;
      cmax = (cmax > 511) ? 511 : cmax;
      ext_r = ($urandom_range(99) < 70) ? span : $urandom_range(256);
      ext_c = ($urandom_range(99) < 70) ? span : $urandom_range(256);
      send_quad($urandom_range(rmax), $urandom_range(cmax),
                $urandom_range((span > step) ? span / step - 1 : 0) * step,
                $urandom_range((span > step) ? span / step - 1 : 0) * step,
                lod, rand_neighbour(), rand_neighbour(), rand_neighbour(),
                rand_neighbour(), ext_r, ext_c);
    end
  endtask

  initial begin
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= CFG_MAX_LOD;
    cfg_data_i         <= '0;
    req_ch.valid       <= 1'b0;
    req_ch.tile_row    <= '0;
    req_ch.tile_col    <= '0;
    req_ch.quad_x      <= '0;
    req_ch.quad_z      <= '0;
    req_ch.lod_self    <= '0;
    req_ch.lod_top     <= '0;
    req_ch.lod_bottom  <= '0;
    req_ch.lod_west    <= '0;
    req_ch.lod_east    <= '0;
    req_ch.extent_rows <= '0;
    req_ch.extent_cols <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed quads under the reset settings: patch edge 64, width 128
    send_quad(0, 0, 0, 0, 0, -1, -1, -1, -1, 64, 64);
    send_quad(0, 0, 5, 0, 0, 3, -1, -1, -1, 64, 64);      // top edge snaps x
    send_quad(0, 0, 13, 63, 0, -1, 2, -1, -1, 64, 64);    // bottom edge snaps x
    send_quad(0, 0, 0, 9, 1, -1, -1, 4, -1, 64, 64);      // left edge snaps z
    send_quad(0, 0, 62, 30, 1, -1, -1, -1, 5, 64, 64);    // right edge snaps z
    send_quad(0, 0, 8, 0, 3, 3, 3, 3, 3, 64, 64);         // equal level, no snap
    send_quad(0, 0, 4, 0, 2, 1, 1, 1, 1, 64, 64);         // finer neighbours
    send_quad(0, 0, 8, 0, 0, -8, -8, -8, -8, 64, 64);     // absent, most negative
    send_quad(0, 0, 32, 0, 0, 7, 7, 7, 7, 64, 64);        // coarsest neighbours
    send_quad(0, 1, 60, 60, 7, 7, 7, 7, 7, 64, 64);       // step past the edge
    send_quad(0, 0, 10, 10, 0, -1, -1, -1, -1, 0, 0);     // empty extents
    send_quad(0, 0, 255, 255, 0, 0, 0, 0, 0, 256, 256);   // pulled back to edge
    send_quad(0, 0, 30, 50, 2, 6, 6, 6, 6, 40, 20);       // clipped extents
    send_quad(1, 1, 63, 63, 0, -1, -1, -1, -1, 64, 64);   // just out of range
    send_quad(511, 511, 255, 255, 7, 7, 7, 7, 7, 511, 511);
    send_quad(0, 1, 20, 20, 0, -1, -1, -1, -1, 64, 64);
    send_quad(0, 3, 63, 63, 0, 0, 0, 0, 0, 64, 64);
    send_quad(0, 0, 1, 1, 0, 1, -1, 1, -1, 3, 3);

    // Random quads over a sweep of register settings, extremes first
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: ;
        1: apply_settings(7, 1024, 21'h1FFFFF);
        2: apply_settings(0, 2, 0);
        3: apply_settings(3, 2047, 21'h100000);
        4: apply_settings(2, 1, 5000);
        5: apply_settings(6, 0, 21'h100001);
        default: apply_settings($urandom, $urandom_range(2047),
                                ($urandom_range(1) == 1) ? $urandom_range(300000, 1000)
                                                         : $urandom);
      endcase
      for (int n = 0; n < PHASE_QUADS; n++) begin
        if ($urandom_range(199) == 0) wait_drained();
        send_random_quad();
      end
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    $display("Sent %0d quads under %0d register settings; %0d results checked, %0d out of range.",
             sent_quads, settings_used, results_seen, out_of_range);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
